FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_AT(lbl, prop, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Sizes, codes, link and command types, and shared helper functions.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int NODE_COUNT  = 1024;
  localparam int ADDR_BITS   = 32;
  localparam int MIN_ORDER   = 12;
  localparam int ORD_W       = 6;
  localparam int LVL_W       = ORD_W + 1;
  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int WORD_BITS   = 32;
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int POOL_WORDS  = NODE_COUNT / WORD_BITS;
  localparam int WORD_W      = $clog2(POOL_WORDS);
  localparam int STACK_DEPTH = 32;
  localparam int STACK_W     = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = STACK_W + 1;
  localparam int CNT_W       = $clog2(NODE_COUNT + 1);
  localparam int AIDX_W      = $clog2(ADDR_BITS);

  localparam logic [ORD_W-1:0] ROOT_ORDER_RESET = ORD_W'(32);

  localparam logic [1:0] LK_NODE = 2'd0;
  localparam logic [1:0] LK_AV   = 2'd1;
  localparam logic [1:0] LK_UNAV = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_BAD       = 2'd2;
  localparam logic [1:0] ST_POOL_FULL = 2'd3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [3:0] OP_NONE        = 4'd0;
  localparam logic [3:0] OP_START       = 4'd1;
  localparam logic [3:0] OP_FAIL        = 4'd2;
  localparam logic [3:0] OP_NODE_RD     = 4'd3;
  localparam logic [3:0] OP_DESCEND     = 4'd4;
  localparam logic [3:0] OP_LEAF        = 4'd5;
  localparam logic [3:0] OP_POOL_RD     = 4'd6;
  localparam logic [3:0] OP_SPLIT       = 4'd7;
  localparam logic [3:0] OP_STACK_RD    = 4'd8;
  localparam logic [3:0] OP_FIX_NODE_RD = 4'd9;
  localparam logic [3:0] OP_FIX_APPLY   = 4'd10;
  localparam logic [3:0] OP_GIVE_RD     = 4'd11;
  localparam logic [3:0] OP_GIVE_WR     = 4'd12;
  localparam logic [3:0] OP_ROOT_WR     = 4'd13;
  localparam logic [3:0] OP_OUT_LOAD    = 4'd14;

  localparam logic [1:0] DN_LEAF = 2'd0;
  localparam logic [1:0] DN_FAIL = 2'd1;
  localparam logic [1:0] DN_READ = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ORD_W-1:0]  ord;
    logic [NODE_W-1:0] idx;
  } link_t;

  typedef struct packed {
    link_t left;
    link_t right;
  } entry_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              side;
  } stk_t;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] status_val;
  } cmd_t;

  typedef struct packed {
    logic       func;
    logic       pre_err;
    logic [1:0] pre_code;
    logic [1:0] down_code;
    logic [1:0] down_fail_code;
    logic       desc_fail;
    logic       pool_short;
    logic       split_more;
    logic       split_last;
    logic       depth_zero;
    logic       merge;
  } dp_stat_t;

  localparam link_t LINK_AV   = '{kind: LK_AV, ord: '1, idx: '1};
  localparam link_t LINK_UNAV = '{kind: LK_UNAV, ord: '1, idx: '1};

  // free order plus one, zero when nothing below is free
  function automatic logic [LVL_W-1:0] link_level(link_t l, logic [ORD_W-1:0] co);
    logic [LVL_W-1:0] r;
    r = '0;
    if (l.kind == LK_AV) r = {1'b0, co} + LVL_W'(1);
    else if (l.kind == LK_NODE) r = {1'b0, l.ord} + LVL_W'(1);
    return r;
  endfunction

  function automatic logic [BIT_W-1:0] first_one(logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

endpackage

FILE: sv/bba_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one allocate or free request.
// ----------------------------------------------------------------------------
interface bba_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [5:0]  req_order;
  logic [31:0] block_address;

  modport source (output valid, func, req_order, block_address, input ready);
  modport sink (input valid, func, req_order, block_address, output ready);
endinterface

FILE: sv/bba_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one allocator result.
// ----------------------------------------------------------------------------
interface bba_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_address;
  logic [1:0]  status;
  logic [5:0]  largest_free_order;

  modport source (output valid, result_address, status, largest_free_order, input ready);
  modport sink (input valid, result_address, status, largest_free_order, output ready);
endinterface

FILE: sv/bba_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: sv/bba_ctrl.sv
// ----------------------------------------------------------------------------
// Buddy allocator controller
// Sequences check, walk down, split and fix-up; owns the channel handshakes.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  dp_stat_t st,
  output cmd_t     cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHECK     = 4'd1;
  localparam logic [3:0] S_DOWN      = 4'd2;
  localparam logic [3:0] S_DOWN_RD   = 4'd3;
  localparam logic [3:0] S_POOL_CHK  = 4'd4;
  localparam logic [3:0] S_TAKE_RD   = 4'd5;
  localparam logic [3:0] S_TAKE_WR   = 4'd6;
  localparam logic [3:0] S_FIX       = 4'd7;
  localparam logic [3:0] S_FIX_SRD   = 4'd8;
  localparam logic [3:0] S_FIX_APPLY = 4'd9;
  localparam logic [3:0] S_GIVE_RD   = 4'd10;
  localparam logic [3:0] S_GIVE_WR   = 4'd11;
  localparam logic [3:0] S_DONE      = 4'd12;

  logic [3:0] state, state_next;
  logic       out_full;
  logic       out_free;

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = out_full;
  assign out_free  = !out_full || rsp_ready;

  always_comb begin
    state_next     = state;
    cmd.op         = OP_NONE;
    cmd.status_val = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = OP_START;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.pre_err) begin
          cmd.op         = OP_FAIL;
          cmd.status_val = st.pre_code;
          state_next     = S_DONE;
        end else begin
          state_next = S_DOWN;
        end
      end
      S_DOWN: begin
        unique case (st.down_code)
          DN_LEAF: state_next = S_POOL_CHK;
          DN_FAIL: begin
            cmd.op         = OP_FAIL;
            cmd.status_val = st.down_fail_code;
            state_next     = S_DONE;
          end
          default: begin
            cmd.op     = OP_NODE_RD;
            state_next = S_DOWN_RD;
          end
        endcase
      end
      S_DOWN_RD: begin
        if (st.desc_fail) begin
          cmd.op         = OP_FAIL;
          cmd.status_val = ST_NO_SPACE;
          state_next     = S_DONE;
        end else begin
          cmd.op     = OP_DESCEND;
          state_next = S_DOWN;
        end
      end
      S_POOL_CHK: begin
        if (st.pool_short) begin
          cmd.op         = OP_FAIL;
          cmd.status_val = ST_POOL_FULL;
          state_next     = S_DONE;
        end else begin
          cmd.op     = OP_LEAF;
          state_next = st.split_more ? S_TAKE_RD : S_FIX;
        end
      end
      S_TAKE_RD: begin
        cmd.op     = OP_POOL_RD;
        state_next = S_TAKE_WR;
      end
      S_TAKE_WR: begin
        cmd.op     = OP_SPLIT;
        state_next = st.split_last ? S_FIX : S_TAKE_RD;
      end
      S_FIX: begin
        if (st.depth_zero) begin
          cmd.op     = OP_ROOT_WR;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_STACK_RD;
          state_next = S_FIX_SRD;
        end
      end
      S_FIX_SRD: begin
        cmd.op     = OP_FIX_NODE_RD;
        state_next = S_FIX_APPLY;
      end
      S_FIX_APPLY: begin
        cmd.op     = OP_FIX_APPLY;
        state_next = st.merge ? S_GIVE_RD : S_FIX;
      end
      S_GIVE_RD: begin
        cmd.op     = OP_GIVE_RD;
        state_next = S_GIVE_WR;
      end
      S_GIVE_WR: begin
        cmd.op     = OP_GIVE_WR;
        state_next = S_FIX;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.op     = OP_OUT_LOAD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == OP_OUT_LOAD) out_full <= 1'b1;
      else if (rsp_ready) out_full <= 1'b0;
    end
  end

endmodule

FILE: sv/bba_datapath.sv
// ----------------------------------------------------------------------------
// Buddy allocator datapath
// Tree links, node pool free map, path stack and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bba_datapath import bba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [ORD_W-1:0]     cfg_wdata,
  input  logic                 in_func,
  input  logic [ORD_W-1:0]     in_req_order,
  input  logic [ADDR_BITS-1:0] in_block_address,
  input  cmd_t                 cmd,
  output dp_stat_t             st,
  output logic [ADDR_BITS-1:0] out_address,
  output logic [1:0]           out_status,
  output logic [ORD_W-1:0]     out_largest
);

  logic [ORD_W-1:0]      root_order;
  link_t                 root_link;
  logic                  func_r;
  logic [ORD_W-1:0]      req_r;
  logic [ADDR_BITS-1:0]  addr_r;
  logic [ORD_W-1:0]      cur;
  logic [DEPTH_W-1:0]    depth;
  link_t                 link_cur;
  link_t                 carried;
  logic [ADDR_BITS-1:0]  result;
  logic [1:0]            status_r;
  logic [CNT_W-1:0]      free_count;
  logic [POOL_WORDS-1:0] fm_valid;
  logic [POOL_WORDS-1:0] fm_has_free;
  logic [WORD_W-1:0]     fm_idx;
  logic [NODE_W-1:0]     give_node;

  logic [ORD_W-1:0]      eff;
  logic [ORD_W-1:0]      cur_m1;
  logic [ORD_W-1:0]      co;
  logic [LVL_W-1:0]      need;
  logic [LVL_W-1:0]      root_lvl;
  logic [ADDR_BITS:0]    mask;
  logic                  bad_order, misaligned, outside;
  entry_t                ent, upd, fill;
  stk_t                  stk;
  logic [LVL_W-1:0]      ll, rl, ml, mr, mx;
  logic                  l_ok, r_ok, alloc_side, addr_side, desc_side;
  link_t                 child, sib, merge_link, fix_link;
  logic [WORD_BITS-1:0]  fm_q, fm_word, fm_new;
  logic [BIT_W-1:0]      take_bit;
  logic [NODE_W-1:0]     new_node;
  logic [WORD_W-1:0]     pool_word;

  logic                  n_we, n_re;
  logic [NODE_W-1:0]     n_waddr, n_raddr;
  logic [2*$bits(link_t)-1:0] n_wdata, n_q;
  logic                  s_we, s_re;
  logic [STACK_W-1:0]    s_waddr, s_raddr;
  logic [$bits(stk_t)-1:0] s_wdata, s_q;
  logic                  fm_we, fm_re;
  logic [WORD_W-1:0]     fm_raddr;

  assign eff    = (root_order > ORD_W'(ADDR_BITS)) ? ORD_W'(ADDR_BITS) : root_order;
  assign cur_m1 = cur - ORD_W'(1);
  assign co     = eff - ORD_W'(depth);
  assign need   = {1'b0, req_r} + LVL_W'(1);

  assign root_lvl   = link_level(root_link, eff);
  assign mask       = ((ADDR_BITS+1)'(1) << req_r) - (ADDR_BITS+1)'(1);
  assign bad_order  = (req_r < ORD_W'(MIN_ORDER)) || (req_r > ORD_W'(ADDR_BITS));
  assign misaligned = (addr_r & mask[ADDR_BITS-1:0]) != '0;
  assign outside    = (addr_r >> eff) != '0;

  assign ent = entry_t'(n_q);
  assign stk = stk_t'(s_q);

  assign ll         = link_level(ent.left, cur_m1);
  assign rl         = link_level(ent.right, cur_m1);
  assign l_ok       = ll >= need;
  assign r_ok       = rl >= need;
  assign alloc_side = !l_ok ? 1'b1 : (!r_ok ? 1'b0 : (rl < ll));
  assign addr_side  = addr_r[cur_m1[AIDX_W-1:0]];
  assign desc_side  = (func_r == FUNC_FREE) ? addr_side : alloc_side;
  assign child      = desc_side ? ent.right : ent.left;

  assign merge_link = (func_r == FUNC_FREE) ? LINK_AV : LINK_UNAV;
  assign fill       = (func_r == FUNC_FREE) ? entry_t'{left: LINK_UNAV, right: LINK_UNAV}
                                            : entry_t'{left: LINK_AV, right: LINK_AV};
  assign sib        = stk.side ? ent.left : ent.right;
  assign upd        = stk.side ? entry_t'{left: ent.left, right: carried}
                               : entry_t'{left: carried, right: ent.right};
  assign ml         = link_level(upd.left, co);
  assign mr         = link_level(upd.right, co);
  assign mx         = (ml > mr) ? ml : mr;
  assign fix_link   = '{kind: LK_NODE,
                        ord: (mx == '0) ? '0 : ORD_W'(mx - LVL_W'(1)),
                        idx: stk.node};

  assign fm_word   = fm_valid[fm_idx] ? fm_q : '1;
  assign take_bit  = first_one(fm_word);
  assign new_node  = {fm_idx, take_bit};
  assign pool_word = WORD_W'(first_one(WORD_BITS'(fm_has_free)));

  always_comb begin
    st.func       = func_r;
    st.pre_err    = 1'b0;
    st.pre_code   = ST_BAD;
    if (bad_order) begin
      st.pre_err = 1'b1;
    end else if (func_r == FUNC_ALLOC) begin
      if (root_lvl < need) begin
        st.pre_err  = 1'b1;
        st.pre_code = ST_NO_SPACE;
      end
    end else if ((req_r > eff) || misaligned || outside) begin
      st.pre_err = 1'b1;
    end

    st.down_fail_code = (func_r == FUNC_FREE) ? ST_BAD : ST_NO_SPACE;
    if (func_r == FUNC_ALLOC) begin
      if (link_cur.kind == LK_AV) st.down_code = DN_LEAF;
      else if (link_cur.kind != LK_NODE || cur <= req_r) st.down_code = DN_FAIL;
      else st.down_code = DN_READ;
    end else begin
      if (link_cur.kind == LK_AV) st.down_code = DN_FAIL;
      else if (link_cur.kind != LK_NODE) st.down_code = DN_LEAF;
      else if (cur <= req_r) st.down_code = DN_FAIL;
      else st.down_code = DN_READ;
    end

    st.desc_fail  = (func_r == FUNC_ALLOC) && !l_ok && !r_ok;
    st.pool_short = free_count < CNT_W'(cur - req_r);
    st.split_more = cur > req_r;
    st.split_last = cur_m1 == req_r;
    st.depth_zero = depth == '0;
    st.merge      = (carried.kind == merge_link.kind) && (sib.kind == merge_link.kind);
  end

  always_comb begin
    n_re    = (cmd.op == OP_NODE_RD) || (cmd.op == OP_FIX_NODE_RD);
    n_raddr = (cmd.op == OP_NODE_RD) ? link_cur.idx : stk.node;
    n_we    = (cmd.op == OP_SPLIT) || ((cmd.op == OP_FIX_APPLY) && !st.merge);
    n_waddr = (cmd.op == OP_SPLIT) ? new_node : stk.node;
    n_wdata = (cmd.op == OP_SPLIT) ? fill : upd;

    s_we    = (cmd.op == OP_DESCEND) || (cmd.op == OP_SPLIT);
    s_waddr = depth[STACK_W-1:0];
    s_wdata = (cmd.op == OP_DESCEND)
              ? {link_cur.idx, desc_side}
              : {new_node, (func_r == FUNC_FREE) ? addr_side : 1'b0};
    s_re    = (cmd.op == OP_STACK_RD);
    s_raddr = STACK_W'(depth - DEPTH_W'(1));

    fm_re    = (cmd.op == OP_POOL_RD) || (cmd.op == OP_GIVE_RD);
    fm_raddr = (cmd.op == OP_POOL_RD) ? pool_word : give_node[NODE_W-1:BIT_W];
    fm_we    = (cmd.op == OP_SPLIT) || (cmd.op == OP_GIVE_WR);
    fm_new   = (cmd.op == OP_SPLIT)
               ? (fm_word & ~(WORD_BITS'(1) << take_bit))
               : (fm_word | (WORD_BITS'(1) << give_node[BIT_W-1:0]));
  end

  bba_ram #(.WIDTH(2 * $bits(link_t)), .DEPTH(NODE_COUNT)) u_node_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .re    (n_re),
    .raddr (n_raddr),
    .rdata (n_q)
  );

  bba_ram #(.WIDTH($bits(stk_t)), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_q)
  );

  bba_ram #(.WIDTH(WORD_BITS), .DEPTH(POOL_WORDS)) u_free_ram (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_idx),
    .wdata (fm_new),
    .re    (fm_re),
    .raddr (fm_raddr),
    .rdata (fm_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      root_order  <= ROOT_ORDER_RESET;
      root_link   <= LINK_UNAV;
      fm_valid    <= '0;
      fm_has_free <= '1;
      free_count  <= CNT_W'(NODE_COUNT);
    end else begin
      if (cfg_we) begin
        root_order  <= cfg_wdata;
        root_link   <= LINK_UNAV;
        fm_valid    <= '0;
        fm_has_free <= '1;
        free_count  <= CNT_W'(NODE_COUNT);
      end
      case (cmd.op)
        OP_START: begin
          func_r   <= in_func;
          req_r    <= in_req_order;
          addr_r   <= in_block_address;
          cur      <= eff;
          depth    <= '0;
          link_cur <= root_link;
          result   <= '0;
          status_r <= ST_OK;
        end
        OP_FAIL: status_r <= cmd.status_val;
        OP_DESCEND: begin
          depth    <= depth + DEPTH_W'(1);
          link_cur <= child;
          cur      <= cur_m1;
          if (func_r == FUNC_ALLOC) result[cur_m1[AIDX_W-1:0]] <= desc_side;
        end
        OP_LEAF: carried <= merge_link;
        OP_POOL_RD: fm_idx <= pool_word;
        OP_GIVE_RD: fm_idx <= give_node[NODE_W-1:BIT_W];
        OP_SPLIT: begin
          fm_valid[fm_idx]    <= 1'b1;
          fm_has_free[fm_idx] <= fm_new != '0;
          free_count          <= free_count - CNT_W'(1);
          depth               <= depth + DEPTH_W'(1);
          cur                 <= cur_m1;
        end
        OP_FIX_APPLY: begin
          depth <= depth - DEPTH_W'(1);
          if (st.merge) begin
            carried   <= merge_link;
            give_node <= stk.node;
          end else begin
            carried <= fix_link;
          end
        end
        OP_GIVE_WR: begin
          fm_valid[fm_idx]    <= 1'b1;
          fm_has_free[fm_idx] <= 1'b1;
          free_count          <= free_count + CNT_W'(1);
        end
        OP_ROOT_WR: root_link <= carried;
        OP_OUT_LOAD: begin
          out_address <= ((status_r == ST_OK) && (func_r == FUNC_ALLOC)) ? result : '0;
          out_status  <= status_r;
          out_largest <= (root_lvl == '0) ? '0 : ORD_W'(root_lvl - LVL_W'(1));
        end
        default: ;
      endcase
    end
  end

  `ASSERT_AT(a_count_bound, free_count <= CNT_W'(NODE_COUNT), "free node count overflow")
  `ASSERT_AT(a_take_has_free, (cmd.op == OP_SPLIT) |-> (fm_word != '0), "split from full word")
  `ASSERT_NEXT(a_split_marks, cmd.op == OP_SPLIT, fm_valid[$past(fm_idx)], "word not marked")

endmodule

FILE: sv/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// Buddy block allocator
// Binary buddy allocator over a pooled sparse split tree.
//
//   channel  dir  transfer when        payload
//   req      in   req.valid & ready    func, req_order, block_address
//   rsp      out  rsp.valid & ready    result_address, status, largest_free_order
//   cfg      in   cfg_we               root_order (6 bits)
//
// One request at a time: a check, a walk down with a node read per level, splits
// that take nodes from the free map, then a fix-up back up the path with merges.
// Each level waits on a registered read of the node RAM or the free-map word RAM.
// A request is taken while the previous result still waits on rsp.
// Reset and any cfg write clear the tree at once; no clearing pass.
// ----------------------------------------------------------------------------
module buddy_block_allocator import bba_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [ORD_W-1:0] cfg_wdata,
  bba_req_if.sink          req,
  bba_rsp_if.source        rsp
);

  cmd_t     cmd;
  dp_stat_t st;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .st        (st),
    .cmd       (cmd)
  );

  bba_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_func          (req.func),
    .in_req_order     (req.req_order),
    .in_block_address (req.block_address),
    .cmd              (cmd),
    .st               (st),
    .out_address      (rsp.result_address),
    .out_status       (rsp.status),
    .out_largest      (rsp.largest_free_order)
  );

endmodule
